[src/hangul_syllable_to_jamo_stream_assert.svh]
// Assertion macros shared by the jamo stream RTL.
`ifndef HANGUL_SYLLABLE_TO_JAMO_STREAM_ASSERT_SVH
`define HANGUL_SYLLABLE_TO_JAMO_STREAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define HSJ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HSJ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/hsj_pkg.sv]
// Types, constants and jamo tables for the jamo stream block.
package hsj_pkg;

   localparam logic [15:0] SYL_FIRST    = 16'hAC00;
   localparam logic [15:0] SYL_LAST     = 16'hD7A3;
   localparam logic [15:0] COMPAT_FIRST = 16'h3130;
   localparam logic [15:0] COMPAT_LAST  = 16'h318F;
   localparam logic [15:0] BACKSLASH    = 16'h005C;

   localparam int FINAL_COUNT     = 28;
   localparam int VOWEL_COUNT     = 21;
   localparam int ROW_FIRST_VOWEL = 19;
   localparam int ROW_FIRST_FINAL = 40;
   localparam int TABLE_ENTRIES   = 68;
   localparam int MAX_PIECES      = 3;
   localparam int BUF_UNITS       = 8;

   // Reciprocals scaled by 2^16, always low by less than one quotient step.
   localparam logic [11:0] RECIP_FINAL = 12'd2340;
   localparam logic [11:0] RECIP_VOWEL = 12'd3120;

   // Register indexes of the control port.
   localparam logic [1:0] CSR_EXTENDED_MODE = 2'd0;
   localparam logic [1:0] CSR_OUTPUT_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_SYLLABLE_MARK = 2'd2;

   localparam logic [15:0] RESET_LIMIT = 16'hFFFF;
   localparam logic [15:0] RESET_MARK  = 16'h318D;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_A, ST_FIX_A, ST_MUL_B, ST_FIX_B, ST_APPEND, ST_EMIT, ST_FINISH
   } hsj_state_type;

   typedef struct packed {
      logic load_item;
      logic mul_a;
      logic fix_a;
      logic mul_b;
      logic fix_b;
      logic append;
      logic emit;
      logic finish;
   } hsj_cmd_type;

   typedef struct packed {
      logic in_syl;
      logic seg_last;
      logic emit_done;
      logic finish_done;
   } hsj_sts_type;

   typedef struct packed {
      logic [1:0]             len;
      logic [2:0][15:0]       piece;
   } hsj_row_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] row;
   } hsj_hit_type;

   function automatic hsj_row_type hsj_mk(logic [1:0] len, logic [15:0] p0,
                                          logic [15:0] p1, logic [15:0] p2);
      hsj_row_type r;
      r.len   = len;
      r.piece = {p2, p1, p0};
      return r;
   endfunction

   // Jamo table: initials, vowels, then finals (the first final row is empty).
   function automatic hsj_row_type hsj_rom(logic [6:0] row);
      hsj_row_type r;
      case (row)
         7'd0:  r = hsj_mk(2'd1, 16'h1100, 16'h0000, 16'h0000);
         7'd1:  r = hsj_mk(2'd2, 16'h1100, 16'h1100, 16'h0000);
         7'd2:  r = hsj_mk(2'd1, 16'h1102, 16'h0000, 16'h0000);
         7'd3:  r = hsj_mk(2'd1, 16'h1103, 16'h0000, 16'h0000);
         7'd4:  r = hsj_mk(2'd2, 16'h1103, 16'h1103, 16'h0000);
         7'd5:  r = hsj_mk(2'd1, 16'h1105, 16'h0000, 16'h0000);
         7'd6:  r = hsj_mk(2'd1, 16'h1106, 16'h0000, 16'h0000);
         7'd7:  r = hsj_mk(2'd1, 16'h1107, 16'h0000, 16'h0000);
         7'd8:  r = hsj_mk(2'd2, 16'h1107, 16'h1107, 16'h0000);
         7'd9:  r = hsj_mk(2'd1, 16'h1109, 16'h0000, 16'h0000);
         7'd10: r = hsj_mk(2'd2, 16'h1109, 16'h1109, 16'h0000);
         7'd11: r = hsj_mk(2'd0, 16'h0000, 16'h0000, 16'h0000);
         7'd12: r = hsj_mk(2'd1, 16'h110C, 16'h0000, 16'h0000);
         7'd13: r = hsj_mk(2'd2, 16'h110C, 16'h110C, 16'h0000);
         7'd14: r = hsj_mk(2'd2, 16'h1112, 16'h110C, 16'h0000);
         7'd15: r = hsj_mk(2'd2, 16'h1112, 16'h1100, 16'h0000);
         7'd16: r = hsj_mk(2'd2, 16'h1112, 16'h1103, 16'h0000);
         7'd17: r = hsj_mk(2'd1, 16'h1111, 16'h0000, 16'h0000);
         7'd18: r = hsj_mk(2'd1, 16'h1112, 16'h0000, 16'h0000);
         7'd19: r = hsj_mk(2'd1, 16'h1161, 16'h0000, 16'h0000);
         7'd20: r = hsj_mk(2'd2, 16'h1161, 16'h1175, 16'h0000);
         7'd21: r = hsj_mk(2'd2, 16'h1175, 16'h1161, 16'h0000);
         7'd22: r = hsj_mk(2'd3, 16'h1175, 16'h1161, 16'h1175);
         7'd23: r = hsj_mk(2'd1, 16'h1165, 16'h0000, 16'h0000);
         7'd24: r = hsj_mk(2'd2, 16'h1165, 16'h1175, 16'h0000);
         7'd25: r = hsj_mk(2'd2, 16'h1175, 16'h1165, 16'h0000);
         7'd26: r = hsj_mk(2'd3, 16'h1175, 16'h1165, 16'h1175);
         7'd27: r = hsj_mk(2'd1, 16'h1169, 16'h0000, 16'h0000);
         7'd28: r = hsj_mk(2'd2, 16'h1169, 16'h1161, 16'h0000);
         7'd29: r = hsj_mk(2'd3, 16'h1169, 16'h1175, 16'h1165);
         7'd30: r = hsj_mk(2'd2, 16'h1169, 16'h1175, 16'h0000);
         7'd31: r = hsj_mk(2'd2, 16'h1175, 16'h1169, 16'h0000);
         7'd32: r = hsj_mk(2'd1, 16'h116E, 16'h0000, 16'h0000);
         7'd33: r = hsj_mk(2'd2, 16'h116E, 16'h1165, 16'h0000);
         7'd34: r = hsj_mk(2'd3, 16'h116E, 16'h1165, 16'h1175);
         7'd35: r = hsj_mk(2'd2, 16'h116E, 16'h1175, 16'h0000);
         7'd36: r = hsj_mk(2'd2, 16'h1175, 16'h116E, 16'h0000);
         7'd37: r = hsj_mk(2'd1, 16'h1173, 16'h0000, 16'h0000);
         7'd38: r = hsj_mk(2'd2, 16'h1173, 16'h1175, 16'h0000);
         7'd39: r = hsj_mk(2'd1, 16'h1175, 16'h0000, 16'h0000);
         7'd41: r = hsj_mk(2'd1, 16'h1100, 16'h0000, 16'h0000);
         7'd42: r = hsj_mk(2'd2, 16'h1100, 16'h1100, 16'h0000);
         7'd43: r = hsj_mk(2'd2, 16'h1100, 16'h1109, 16'h0000);
         7'd44: r = hsj_mk(2'd1, 16'h1102, 16'h0000, 16'h0000);
         7'd45: r = hsj_mk(2'd2, 16'h1102, 16'h110C, 16'h0000);
         7'd46: r = hsj_mk(2'd2, 16'h1102, 16'h1112, 16'h0000);
         7'd47: r = hsj_mk(2'd1, 16'h1103, 16'h0000, 16'h0000);
         7'd48: r = hsj_mk(2'd1, 16'h1105, 16'h0000, 16'h0000);
         7'd49: r = hsj_mk(2'd2, 16'h1105, 16'h1100, 16'h0000);
         7'd50: r = hsj_mk(2'd2, 16'h1105, 16'h1106, 16'h0000);
         7'd51: r = hsj_mk(2'd2, 16'h1105, 16'h1107, 16'h0000);
         7'd52: r = hsj_mk(2'd2, 16'h1105, 16'h1109, 16'h0000);
         7'd53: r = hsj_mk(2'd2, 16'h1105, 16'h1110, 16'h0000);
         7'd54: r = hsj_mk(2'd2, 16'h1105, 16'h1111, 16'h0000);
         7'd55: r = hsj_mk(2'd2, 16'h1105, 16'h1112, 16'h0000);
         7'd56: r = hsj_mk(2'd1, 16'h1106, 16'h0000, 16'h0000);
         7'd57: r = hsj_mk(2'd1, 16'h1107, 16'h0000, 16'h0000);
         7'd58: r = hsj_mk(2'd2, 16'h1107, 16'h1109, 16'h0000);
         7'd59: r = hsj_mk(2'd1, 16'h1109, 16'h0000, 16'h0000);
         7'd60: r = hsj_mk(2'd2, 16'h1109, 16'h1109, 16'h0000);
         7'd61: r = hsj_mk(2'd1, 16'h110B, 16'h0000, 16'h0000);
         7'd62: r = hsj_mk(2'd1, 16'h110C, 16'h0000, 16'h0000);
         7'd63: r = hsj_mk(2'd1, 16'h110E, 16'h0000, 16'h0000);
         7'd64: r = hsj_mk(2'd1, 16'h110F, 16'h0000, 16'h0000);
         7'd65: r = hsj_mk(2'd1, 16'h1110, 16'h0000, 16'h0000);
         7'd66: r = hsj_mk(2'd1, 16'h1111, 16'h0000, 16'h0000);
         7'd67: r = hsj_mk(2'd1, 16'h1112, 16'h0000, 16'h0000);
         default: r = hsj_mk(2'd0, 16'h0000, 16'h0000, 16'h0000);
      endcase
      return r;
   endfunction

   // Compatibility jamo to the last table row that names it.
   function automatic hsj_hit_type hsj_compat_row(logic [15:0] unit);
      hsj_hit_type h;
      h.hit = 1'b1;
      case (unit)
         16'h3131: h.row = 7'd41;
         16'h3132: h.row = 7'd42;
         16'h3133: h.row = 7'd43;
         16'h3134: h.row = 7'd44;
         16'h3135: h.row = 7'd45;
         16'h3136: h.row = 7'd46;
         16'h3137: h.row = 7'd47;
         16'h3138: h.row = 7'd4;
         16'h3139: h.row = 7'd48;
         16'h313A: h.row = 7'd49;
         16'h313B: h.row = 7'd50;
         16'h313C: h.row = 7'd51;
         16'h313D: h.row = 7'd52;
         16'h313E: h.row = 7'd53;
         16'h313F: h.row = 7'd54;
         16'h3140: h.row = 7'd55;
         16'h3141: h.row = 7'd56;
         16'h3142: h.row = 7'd57;
         16'h3143: h.row = 7'd8;
         16'h3144: h.row = 7'd58;
         16'h3145: h.row = 7'd59;
         16'h3146: h.row = 7'd60;
         16'h3147: h.row = 7'd61;
         16'h3148: h.row = 7'd62;
         16'h3149: h.row = 7'd13;
         16'h314A: h.row = 7'd63;
         16'h314B: h.row = 7'd64;
         16'h314C: h.row = 7'd65;
         16'h314D: h.row = 7'd66;
         16'h314E: h.row = 7'd67;
         default: begin
            // Vowels map in order onto the vowel rows.
            if (unit >= 16'h314F && unit <= 16'h3163) begin
               h.row = 7'(unit - 16'h314F + 16'(ROW_FIRST_VOWEL));
            end else begin
               h.hit = 1'b0;
               h.row = 7'd0;
            end
         end
      endcase
      return h;
   endfunction

endpackage

[src/hangul_syllable_to_jamo_stream.sv]
// Top level of the Hangul syllable to jamo stream converter.
//
// Input words arrive on req_ (tdata = code unit, tlast = end of string); one
// word is taken at a time. Results leave on rsp_: tuser says the unit is
// data (0 marks a bare end-of-string word), tlast ends the run of one input.
// The user must write control registers through csr_ only while the block
// is idle; the block itself does not enforce this. A word passes an accept
// state, for a syllable the multiply and correction steps of the split, the
// filling of the unit buffer, the emission of its units and a closing state.
// Results are held in an output register; a stall on rsp_tready holds the
// current result and pauses emission without losing anything.
// Reset (synchronous) restores extended mode, a limit of 65535 and the
// default mark, and clears the escape flag, count and overflow state.
// At the end of each string the escape flag, count and overflow clear.
module hangul_syllable_to_jamo_stream
   import hsj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // code_unit[15:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // jamo_unit[15:0], string_done[16], total_length[32:17], overflow[33]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,   // unit_valid[0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

`include "hangul_syllable_to_jamo_stream_assert.svh"

   hsj_cmd_type cmd;
   hsj_sts_type sts;

   // Sequencer.
   hsj_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath.
   hsj_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Checks on the sequencing.
   `HSJ_ASSERT_NXT(a_one_word, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while busy")
   `HSJ_ASSERT_IMP(a_bare_mark, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tlast && rsp_tdata[16], "bare marker not closing")
   `HSJ_ASSERT_IMP(a_done_last, clock, reset, rsp_tvalid && rsp_tdata[16], rsp_tlast, "string done without run end")
   `HSJ_ASSERT_IMP(a_len_nonzero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[32:17] != 16'd0, "emitted unit with zero length")

endmodule

[src/hsj_ctl.sv]
// Sequencing state machine of the jamo stream block.
module hsj_ctl
   import hsj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  hsj_sts_type sts,
   output hsj_cmd_type cmd
);

   hsj_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = sts.in_syl ? ST_MUL_A : ST_APPEND;
            end
         end
         ST_MUL_A: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_FIX_A;
         end
         ST_FIX_A: begin
            cmd.fix_a = 1'b1;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_FIX_B;
         end
         ST_FIX_B: begin
            cmd.fix_b = 1'b1;
            state_in  = ST_APPEND;
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            if (sts.seg_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            if (sts.finish_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/hsj_dp.sv]
// Datapath: control registers, decode, unit buffer, limit and output register.
module hsj_dp
   import hsj_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  hsj_cmd_type cmd,
   output hsj_sts_type sts,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   // Control registers.
   logic        ext_mode_ff;
   logic [15:0] out_limit_ff;
   logic [15:0] syl_mark_ff;

   // String state.
   logic        esc_pending_ff, esc_pending_in;
   logic [15:0] count_ff, count_in;
   logic        limit_hit_ff, limit_hit_in;

   // Current word.
   logic [15:0] unit_ff;
   logic        eos_ff;
   logic        lit_en_ff;
   logic [15:0] lit_ff;
   logic [2:0]  row_en_ff;
   logic [6:0]  row_ff [3];
   logic [25:0] prod_a_ff;
   logic [20:0] prod_b_ff;
   logic [8:0]  t_ff;
   logic [1:0]  seg_ff;
   logic [3:0]  n_ff;
   logic [3:0]  k_ff;
   logic        any_ff;
   logic [15:0] buf_ff [BUF_UNITS];

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_valid_ff, o_last_ff, o_done_ff, o_ovf_ff;
   logic [15:0] o_unit_ff, o_total_ff;

   // Input classification.
   logic [15:0] in_unit;
   logic        in_bs, in_syl, in_cmp, in_lit;
   hsj_hit_type in_hit;

   assign in_unit = req_tdata;
   assign in_hit  = hsj_compat_row(in_unit);
   assign in_bs   = !esc_pending_ff && ext_mode_ff && (in_unit == BACKSLASH);
   assign in_syl  = !esc_pending_ff && (in_unit >= SYL_FIRST) && (in_unit <= SYL_LAST);
   assign in_cmp  = !esc_pending_ff && ext_mode_ff && in_hit.hit;
   assign in_lit  = !esc_pending_ff && !in_bs && !in_syl && !in_cmp;

   // Syllable split: two reciprocal multiplies, each followed by one correction.
   logic [13:0] syl_off;
   logic [9:0]  qa;
   logic [14:0] ra;
   logic [8:0]  t_fix;
   logic [4:0]  fin_fix;
   logic [4:0]  qb;
   logic [8:0]  rb;
   logic [4:0]  ini_fix;
   logic [4:0]  vow_fix;

   assign syl_off = 14'(unit_ff - SYL_FIRST);
   assign qa      = prod_a_ff[25:16];
   assign ra      = {1'b0, syl_off} - 15'(15'(qa) * 15'(FINAL_COUNT));
   assign t_fix   = (ra >= 15'(FINAL_COUNT)) ? 9'(qa + 10'd1) : qa[8:0];
   assign fin_fix = (ra >= 15'(FINAL_COUNT)) ? 5'(ra - 15'(FINAL_COUNT)) : ra[4:0];
   assign qb      = prod_b_ff[20:16];
   assign rb      = t_ff - 9'(9'(qb) * 9'(VOWEL_COUNT));
   assign ini_fix = (rb >= 9'(VOWEL_COUNT)) ? 5'(qb + 5'd1) : qb;
   assign vow_fix = (rb >= 9'(VOWEL_COUNT)) ? 5'(rb - 9'(VOWEL_COUNT)) : rb[4:0];

   // Segment being appended: the literal, then up to three table rows.
   hsj_row_type seg_row;
   logic [1:0]  row_sel;

   assign row_sel = 2'(seg_ff - 2'd1);
   always_comb begin
      if (seg_ff == 2'd0) begin
         seg_row = hsj_mk(lit_en_ff ? 2'd1 : 2'd0, lit_ff, 16'h0000, 16'h0000);
      end else if (row_en_ff[row_sel]) begin
         seg_row = hsj_rom(row_ff[row_sel]);
      end else begin
         seg_row = hsj_mk(2'd0, 16'h0000, 16'h0000, 16'h0000);
      end
   end

   // Limit check and next emitted count.
   logic        slot_free, pending, blocked, reached, marker;
   logic [15:0] cnt_next;

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign pending   = (k_ff != n_ff);
   assign blocked   = limit_hit_ff || (count_ff >= out_limit_ff);
   assign cnt_next  = 16'(count_ff + 16'd1);
   assign reached   = (cnt_next >= out_limit_ff);
   assign marker    = eos_ff && !any_ff;

   logic emit_load, mark_load, clear_str;

   assign emit_load = cmd.emit && pending && !blocked && slot_free;
   assign mark_load = cmd.finish && marker && slot_free;
   assign clear_str = cmd.finish && eos_ff && (!marker || slot_free);

   assign sts.in_syl      = in_syl;
   assign sts.seg_last    = (seg_ff == 2'd3);
   assign sts.emit_done   = !pending || blocked;
   assign sts.finish_done = !marker || slot_free;

   // Control register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_mode_ff  <= 1'b1;
         out_limit_ff <= RESET_LIMIT;
         syl_mark_ff  <= RESET_MARK;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_EXTENDED_MODE: ext_mode_ff  <= csr_wdata[0];
            CSR_OUTPUT_LIMIT:  out_limit_ff <= csr_wdata;
            CSR_SYLLABLE_MARK: syl_mark_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Next string state.
   always_comb begin
      esc_pending_in = esc_pending_ff;
      count_in       = count_ff;
      limit_hit_in   = limit_hit_ff;
      if (cmd.load_item) begin
         esc_pending_in = in_bs;
      end
      if (cmd.emit && pending && blocked) begin
         limit_hit_in = 1'b1;
      end
      if (emit_load) begin
         count_in     = cnt_next;
         limit_hit_in = reached;
      end
      if (clear_str) begin
         esc_pending_in = 1'b0;
         count_in       = '0;
         limit_hit_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_pending_ff <= 1'b0;
         count_ff       <= '0;
         limit_hit_ff   <= 1'b0;
      end else begin
         esc_pending_ff <= esc_pending_in;
         count_ff       <= count_in;
         limit_hit_ff   <= limit_hit_in;
      end
   end

   // Word decode and buffer fill.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         unit_ff   <= in_unit;
         eos_ff    <= req_tlast;
         lit_en_ff <= in_syl || in_lit;
         lit_ff    <= in_syl ? syl_mark_ff : in_unit;
         row_en_ff <= in_syl ? 3'b111 : {2'b00, in_cmp};
         row_ff[0] <= in_hit.row;
         seg_ff    <= 2'd0;
         n_ff      <= 4'd0;
         k_ff      <= 4'd0;
         any_ff    <= 1'b0;
      end
      if (cmd.mul_a) begin
         prod_a_ff <= 26'(syl_off) * 26'(RECIP_FINAL);
      end
      if (cmd.fix_a) begin
         t_ff      <= t_fix;
         row_ff[2] <= 7'(fin_fix + 5'd0) + 7'(ROW_FIRST_FINAL);
      end
      if (cmd.mul_b) begin
         prod_b_ff <= 21'(t_ff) * 21'(RECIP_VOWEL);
      end
      if (cmd.fix_b) begin
         row_ff[0] <= 7'(ini_fix);
         row_ff[1] <= 7'(vow_fix) + 7'(ROW_FIRST_VOWEL);
      end
      if (cmd.append) begin
         for (int i = 0; i < BUF_UNITS; i++) begin
            if ((4'(i) >= n_ff) && (4'(4'(i) - n_ff) < {2'b00, seg_row.len})) begin
               buf_ff[i] <= seg_row.piece[2'(4'(i) - n_ff)];
            end
         end
         n_ff   <= 4'(n_ff + {2'b00, seg_row.len});
         seg_ff <= 2'(seg_ff + 2'd1);
      end
      if (emit_load) begin
         k_ff   <= 4'(k_ff + 4'd1);
         any_ff <= 1'b1;
      end
   end

   // Output register: loaded when free or being taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_load || mark_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         o_valid_ff <= 1'b1;
         o_unit_ff  <= buf_ff[k_ff[2:0]];
         o_last_ff  <= (4'(k_ff + 4'd1) == n_ff) || reached;
         o_done_ff  <= ((4'(k_ff + 4'd1) == n_ff) || reached) && eos_ff;
         o_total_ff <= cnt_next;
         o_ovf_ff   <= reached;
      end else if (mark_load) begin
         o_valid_ff <= 1'b0;
         o_unit_ff  <= '0;
         o_last_ff  <= 1'b1;
         o_done_ff  <= 1'b1;
         o_total_ff <= count_ff;
         o_ovf_ff   <= limit_hit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = o_valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {6'b000000, o_ovf_ff, o_total_ff, o_done_ff, o_unit_ff};

endmodule
